// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LFP_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LFP_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

// File: hdl/lfp_pkg.sv
`default_nettype none

package lfp_pkg;

  // Frame layout: two headers, six payload bytes, one checksum byte.
  localparam int FRAME_BYTES   = 9;
  localparam int PAYLOAD_COUNT = FRAME_BYTES - 3;
  localparam int PAY_IDX_W     = $clog2(PAYLOAD_COUNT);

  localparam logic [7:0]  HEADER_RESET = 8'h59;
  localparam logic [16:0] TEMP_OFFSET  = 17'd2048;

  // Result packing: checksum_ok, distance, strength, temperature_eighths.
  localparam int RESULT_BITS = 1 + 16 + 16 + 17;
  localparam int OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

  // Front-end parser phase.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR2,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  // What the back end does with a queued byte.
  typedef enum logic [1:0] {
    K_FIRST,
    K_ADD,
    K_PAYLOAD,
    K_CHECK
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [PAY_IDX_W-1:0] idx;
    logic [7:0]           data;
  } entry_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } deq_t;

endpackage

`default_nettype wire

// File: hdl/lfp_front.sv
`default_nettype none

`include "assert_macros.svh"

module lfp_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [7:0]            in_tdata,   // [7:0] rx_byte
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [7:0]            cfg_data,   // [7:0] header_byte
  input  wire                   q_full,
  output logic                  push,
  output lfp_pkg::entry_t       push_entry
);

  logic [7:0]                   header_r;
  lfp_pkg::phase_t              phase_r, phase_nxt;
  logic [lfp_pkg::PAY_IDX_W-1:0] pay_idx_r, pay_idx_nxt;
  logic                         fire;
  logic                         match;
  logic                         last_pay;

  // Header register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= lfp_pkg::HEADER_RESET;
    end else if (cfg_valid) begin
      header_r <= cfg_data;
    end
  end

  // A byte is taken whenever the queue has room, even one that is dropped.
  assign in_tready = !q_full;
  assign fire      = in_tvalid && !q_full;
  assign match     = (in_tdata == header_r);
  assign last_pay  = (pay_idx_r == lfp_pkg::PAY_IDX_W'(lfp_pkg::PAYLOAD_COUNT - 1));

  // Next-state logic.
  always_comb begin
    phase_nxt   = phase_r;
    pay_idx_nxt = pay_idx_r;
    unique case (phase_r)
      lfp_pkg::PH_HUNT: begin
        if (fire && match) begin
          phase_nxt = lfp_pkg::PH_HDR2;
        end
      end
      lfp_pkg::PH_HDR2: begin
        if (fire) begin
          phase_nxt   = match ? lfp_pkg::PH_PAYLOAD : lfp_pkg::PH_HUNT;
          pay_idx_nxt = '0;
        end
      end
      lfp_pkg::PH_PAYLOAD: begin
        if (fire) begin
          if (last_pay) begin
            phase_nxt = lfp_pkg::PH_CHECK;
          end else begin
            pay_idx_nxt = pay_idx_r + 1'b1;
          end
        end
      end
      lfp_pkg::PH_CHECK: begin
        if (fire) begin
          phase_nxt = lfp_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_nxt = lfp_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lfp_pkg::PH_HUNT;
      pay_idx_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pay_idx_r <= pay_idx_nxt;
    end
  end

  // Output logic: classify the byte and request a queue write.
  always_comb begin
    push            = 1'b0;
    push_entry.kind = lfp_pkg::K_FIRST;
    push_entry.idx  = pay_idx_r;
    push_entry.data = in_tdata;
    unique case (phase_r)
      lfp_pkg::PH_HUNT: begin
        push            = fire && match;
        push_entry.kind = lfp_pkg::K_FIRST;
      end
      lfp_pkg::PH_HDR2: begin
        push            = fire && match;
        push_entry.kind = lfp_pkg::K_ADD;
      end
      lfp_pkg::PH_PAYLOAD: begin
        push            = fire;
        push_entry.kind = lfp_pkg::K_PAYLOAD;
      end
      lfp_pkg::PH_CHECK: begin
        push            = fire;
        push_entry.kind = lfp_pkg::K_CHECK;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // A matching first header always moves on to the second-header phase.
  `LFP_ASSERT_NXT(a_hunt_to_hdr2, clk, rst_n,
    fire && match && (phase_r == lfp_pkg::PH_HUNT), phase_r == lfp_pkg::PH_HDR2,
    "first header did not advance the parser")

  // The payload index never runs past the last payload byte.
  `LFP_ASSERT_IMP(a_idx_range, clk, rst_n, phase_r == lfp_pkg::PH_PAYLOAD,
    pay_idx_r <= lfp_pkg::PAY_IDX_W'(lfp_pkg::PAYLOAD_COUNT - 1),
    "payload index out of range")

endmodule

`default_nettype wire

// File: hdl/lfp_queue.sv
`default_nettype none

`include "assert_macros.svh"

module lfp_queue #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  lfp_pkg::entry_t     push_entry,
  output logic                full,
  input  wire                 pop,
  output lfp_pkg::deq_t       deq
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lfp_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign do_pop    = pop && (count_r != '0);
  assign deq.valid = (count_r != '0);
  assign deq.entry = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `LFP_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full,
    "queue written while full")

endmodule

`default_nettype wire

// File: hdl/lfp_back.sv
`default_nettype none

`include "assert_macros.svh"

module lfp_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  lfp_pkg::deq_t                    deq,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [0] checksum_ok, [16:1] distance, [32:17] strength,
  // [49:33] temperature_eighths, upper bits zero
  output logic [lfp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [7:0]                        sum_r;
  logic [7:0]                        pay_r [lfp_pkg::PAYLOAD_COUNT];
  logic                              out_valid_r;
  logic [lfp_pkg::RESULT_BITS-1:0]   out_data_r;
  logic                              out_free;
  logic                              is_check;
  logic                              ok;
  logic [15:0]                       distance;
  logic [15:0]                       strength;
  logic [16:0]                       temp;

  assign out_free = !out_valid_r || out_tready;
  assign is_check = (deq.entry.kind == lfp_pkg::K_CHECK);
  assign pop      = deq.valid && (!is_check || out_free);

  // Result fields decoded from the gathered payload.
  assign ok       = (deq.entry.data == sum_r);
  assign distance = {pay_r[1], pay_r[0]};
  assign strength = {pay_r[3], pay_r[2]};
  assign temp     = {1'b0, pay_r[5], pay_r[4]} - lfp_pkg::TEMP_OFFSET;

  // Running sum over headers and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (pop) begin
      case (deq.entry.kind) inside
        lfp_pkg::K_FIRST:                     sum_r <= deq.entry.data;
        lfp_pkg::K_ADD, lfp_pkg::K_PAYLOAD:   sum_r <= sum_r + deq.entry.data;
        default:                              sum_r <= '0;
      endcase
    end
  end

  // Payload bytes.
  always_ff @(posedge clk) begin
    if (pop && (deq.entry.kind == lfp_pkg::K_PAYLOAD) &&
        (deq.entry.idx < lfp_pkg::PAY_IDX_W'(lfp_pkg::PAYLOAD_COUNT))) begin
      pay_r[deq.entry.idx] <= deq.entry.data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && is_check) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_check) begin
      out_data_r <= {temp, strength, distance, ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lfp_pkg::OUT_TDATA_W - lfp_pkg::RESULT_BITS){1'b0}}, out_data_r};

  // Each checksum byte leaves the sum cleared for the next frame.
  `LFP_ASSERT_NXT(a_sum_clear, clk, rst_n, pop && is_check, sum_r == 8'd0,
    "running sum not cleared after checksum")

  // A result is never loaded over one that is still waiting.
  `LFP_ASSERT_IMP(a_no_overwrite, clk, rst_n, pop && is_check,
    !out_valid_r || out_tready, "pending result overwritten")

endmodule

`default_nettype wire

// File: hdl/lidar_frame_parser_top.sv
// Path: an accepted checksum byte is written into the queue, popped by the result stage and
// loaded into the output register, which then raises out_tvalid.
// Throughput: one byte per cycle while the queue has room; a four-entry queue separates the
// parser from the result stage, so a short stall on either side does not stop the other.
// Reset (synchronous, rst_n low): parser hunts the first header, sum is zero,
// header register is 0x59, queue and output register are empty.
`default_nettype none

module lidar_frame_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [0] checksum_ok, [16:1] distance, [32:17] strength,
  // [49:33] temperature_eighths, [55:50] zero
  output logic [lfp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [7:0]                       cfg_data    // [7:0] header_byte
);

  logic            push;
  logic            pop;
  logic            q_full;
  lfp_pkg::entry_t push_entry;
  lfp_pkg::deq_t   deq;

  // Byte classifier.
  lfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue between classifier and result stage.
  lfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .deq        (deq)
  );

  // Sum, payload capture and result register.
  lfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .deq        (deq),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: tb/lidar_frame_parser_top_tb.sv
`default_nettype none

module lidar_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] PH_FIRST_HDR  = 4'd0;
  localparam logic [3:0] PH_SECOND_HDR = 4'd1;
  localparam logic [3:0] PH_FIRST_PAY  = 4'd2;
  localparam logic [3:0] PH_CHECKSUM   = 4'd8;
  localparam int         DRAIN_CYCLES  = 16;
  localparam int         PHASE_BYTES   = 255;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        checksum_ok;
    logic [15:0] distance;
    logic [15:0] strength;
    logic [16:0] temperature;
  } range_sample_t;

  // Tracks the frame parser state and holds the samples still owed by the block.
  class frame_scoreboard;
    logic [7:0]    header;
    logic [3:0]    phase;
    logic [7:0]    sum;
    logic [7:0]    payload [lfp_pkg::PAYLOAD_COUNT];
    range_sample_t owed_samples[$];
    int            errors;

    function new();
      header = lfp_pkg::HEADER_RESET;
      phase  = PH_FIRST_HDR;
      sum    = 8'h00;
      errors = 0;
      foreach (payload[i]) payload[i] = 8'h00;
    endfunction

    function void set_header(logic [7:0] value);
      header = value;
    endfunction

    function int pending();
      return owed_samples.size();
    endfunction

    // Advance the parser by one accepted byte request.
    function void note_byte(logic [7:0] b);
      range_sample_t s;
      logic [16:0]   raw_temp;
      if (phase > PH_CHECKSUM) phase = PH_FIRST_HDR;
      if (phase == PH_FIRST_HDR) begin
        if (b == header) begin
          sum   = b;
          phase = PH_SECOND_HDR;
        end
      end else if (phase == PH_SECOND_HDR) begin
        if (b == header) begin
          sum   = sum + b;
          phase = PH_FIRST_PAY;
        end else begin
          phase = PH_FIRST_HDR;
        end
      end else if (phase < PH_CHECKSUM) begin
        payload[3'(phase - PH_FIRST_PAY)] = b;
        sum   = sum + b;
        phase = phase + 4'd1;
      end else begin
        raw_temp      = {1'b0, payload[5], payload[4]};
        s.checksum_ok = (b == sum);
        s.distance    = {payload[1], payload[0]};
        s.strength    = {payload[3], payload[2]};
        s.temperature = raw_temp - lfp_pkg::TEMP_OFFSET;
        owed_samples.push_back(s);
        phase = PH_FIRST_HDR;
        sum   = 8'h00;
      end
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      errors++;
    endtask

    // Compare one accepted result request against the oldest owed sample.
    task check_result(logic [lfp_pkg::OUT_TDATA_W-1:0] d);
      range_sample_t want;
      if (owed_samples.size() == 0) begin
        report_mismatch("unexpected result", d[31:0], 32'h0);
      end else begin
        want = owed_samples.pop_front();
        if (d[0] !== want.checksum_ok)
          report_mismatch("checksum_ok", 32'(d[0]), 32'(want.checksum_ok));
        if (d[16:1] !== want.distance)
          report_mismatch("distance", 32'(d[16:1]), 32'(want.distance));
        if (d[32:17] !== want.strength)
          report_mismatch("strength", 32'(d[32:17]), 32'(want.strength));
        if (d[49:33] !== want.temperature)
          report_mismatch("temperature_eighths", 32'(d[49:33]), 32'(want.temperature));
        if (d[lfp_pkg::OUT_TDATA_W-1:50] !== '0)
          report_mismatch("padding", 32'(d[lfp_pkg::OUT_TDATA_W-1:50]), 32'h0);
      end
    endtask
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = 8'h00;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lfp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [7:0]                      cfg_data   = 8'h00;

  frame_scoreboard sb = new();
  int              hold_cycles = 0;

  lidar_frame_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure: randomly chosen modes of random length, plus a long hold.
  int stall_mode = 0;
  int mode_left  = 0;
  int rx_cycle   = 0;

  always @(negedge clk) begin
    rx_cycle++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_cycle % 5) != 0;
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Every accepted result request goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
  endtask

  // Offer a byte stream in bursts of random length with random gaps.
  task automatic drive_bytes(input byte_q_t bytes);
    int burst;
    int gap;
    burst = $urandom_range(1, 40);
    foreach (bytes[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      send_byte(bytes[i]);
      burst--;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic write_header(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_header(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every owed sample, then let the byte queue empty.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_frame(input logic [7:0] hdr,
                           input logic [7:0] pay[lfp_pkg::PAYLOAD_COUNT],
                           input bit good_sum, inout byte_q_t q);
    logic [7:0] s;
    s = hdr + hdr;
    q.push_back(hdr);
    q.push_back(hdr);
    foreach (pay[i]) begin
      q.push_back(pay[i]);
      s = s + pay[i];
    end
    q.push_back(good_sum ? s : s ^ 8'(1 + $urandom_range(0, 254)));
  endtask

  // Mostly well-formed frames with random content, some broken frames and noise.
  task automatic make_traffic(input logic [7:0] hdr, input int count, output byte_q_t q);
    logic [7:0] pay[lfp_pkg::PAYLOAD_COUNT];
    int         pick;
    int         fill;
    q = {};
    while (q.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        fill = $urandom_range(0, 9);
        foreach (pay[i])
          pay[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
        add_frame(hdr, pay, $urandom_range(0, 3) != 0, q);
      end else if (pick < 80) begin
        q.push_back(hdr);
        q.push_back(hdr ^ 8'(1 + $urandom_range(0, 254)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
      end else begin
        q.push_back(hdr);
        q.push_back(hdr);
        repeat ($urandom_range(0, 5)) q.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    byte_q_t    stream;
    logic [7:0] pay[lfp_pkg::PAYLOAD_COUNT];
    logic [7:0] phase_headers[6];

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme payloads under the reset header, a bad checksum,
    // and a second byte that is not a header.
    stream = {};
    foreach (pay[i]) pay[i] = 8'h00;
    add_frame(lfp_pkg::HEADER_RESET, pay, 1'b1, stream);
    foreach (pay[i]) pay[i] = 8'hFF;
    add_frame(lfp_pkg::HEADER_RESET, pay, 1'b0, stream);
    stream.push_back(lfp_pkg::HEADER_RESET);
    stream.push_back(8'h00);
    drive_bytes(stream);
    wait_drained();

    // Random phases, each under its own header value.
    phase_headers = '{8'h00, 8'hFF, 8'($urandom), lfp_pkg::HEADER_RESET, 8'($urandom),
                      8'hA6};
    foreach (phase_headers[p]) begin
      write_header(phase_headers[p]);
      make_traffic(phase_headers[p], PHASE_BYTES, stream);
      // Long receiver hold while the sender keeps offering, to fill the block.
      if (p == 1) hold_cycles = 400;
      drive_bytes(stream);
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/lfp_pkg.sv
hdl/lfp_front.sv
hdl/lfp_queue.sv
hdl/lfp_back.sv
hdl/lidar_frame_parser_top.sv
tb/lidar_frame_parser_top_tb.sv
